// ----- rtl/core/cme_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cme_pkg
// Shared types, codes and constants of the card machine instruction executor.
// ----------------------------------------------------------------------------
package cme_pkg;

	// Memory geometry.
	localparam int MEM_WORDS   = 100;
	localparam int BLOCK_WORDS = 10;
	localparam int MEM_AW      = $clog2(MEM_WORDS);
	localparam int CNT_W       = $clog2(BLOCK_WORDS);
	localparam int ADDR_W      = 7;
	localparam int WORD_W      = 32;

	// The counter stops at this address even when memory is larger.
	localparam int PC_LIMIT = 99;
	localparam int DEC_BASE = 10;

	// Item operation codes.
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STEP  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	// Result status codes.
	localparam logic [2:0] STAT_EXEC  = 3'd0;
	localparam logic [2:0] STAT_READ  = 3'd1;
	localparam logic [2:0] STAT_PRINT = 3'd2;
	localparam logic [2:0] STAT_HALT  = 3'd3;
	localparam logic [2:0] STAT_END   = 3'd4;
	localparam logic [2:0] STAT_BAD   = 3'd5;
	localparam logic [2:0] STAT_ACK   = 3'd6;

	// ASCII characters of the instruction set.
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_G    = 8'h47;
	localparam logic [7:0] CH_D    = 8'h44;
	localparam logic [7:0] CH_P    = 8'h50;
	localparam logic [7:0] CH_H    = 8'h48;
	localparam logic [7:0] CH_L    = 8'h4C;
	localparam logic [7:0] CH_R    = 8'h52;
	localparam logic [7:0] CH_S    = 8'h53;
	localparam logic [7:0] CH_C    = 8'h43;
	localparam logic [7:0] CH_B    = 8'h42;
	localparam logic [7:0] CH_T    = 8'h54;

	// Input item.
	typedef struct packed {
		logic [1:0]        op;
		logic [ADDR_W-1:0] address;
		logic [WORD_W-1:0] word;
	} cmd_item_t;

	// Result item.
	typedef struct packed {
		logic [2:0]        status;
		logic [WORD_W-1:0] data_word;
		logic [3:0]        block;
		logic              toggle;
		logic              last;
	} res_item_t;

	// Memory request from the sequencer.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
		logic              clear;
	} mem_req_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_DATA,
		S_EMIT
	} state_t;

	// What to do with data read in the data state.
	typedef enum logic [1:0] {
		DOP_LOAD_R,
		DOP_COMPARE,
		DOP_PRINT
	} dop_t;

	// True when the character is an ASCII decimal digit.
	function automatic logic is_digit(input logic [7:0] c);
		logic [7:0] d;
		d = c - CH_ZERO;
		return d < 8'(DEC_BASE);
	endfunction

endpackage

// ----- rtl/core/cme_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cme_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 100
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/cme_vld.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cme_vld
// One written flag per memory word. A word whose flag is clear reads as zero,
// so reset and a job clear empty the whole memory at once.
// ----------------------------------------------------------------------------
module cme_vld (
	input  logic              clk,
	input  logic              arst_n,
	input  cme_pkg::mem_req_t mem,
	output logic              rd_vld
);

	logic [cme_pkg::MEM_WORDS-1:0] vld_q;
	logic                          rd_vld_q;

	// Flags are set on a write and all dropped on a clear; the read flag
	// follows the RAM read latency.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem.clear) begin
				vld_q <= '0;
			end else if (mem.we) begin
				vld_q[mem.waddr[cme_pkg::MEM_AW-1:0]] <= 1'b1;
			end
			rd_vld_q <= vld_q[mem.raddr[cme_pkg::MEM_AW-1:0]];
		end
	end

	assign rd_vld = rd_vld_q;

endmodule

// ----- rtl/core/cme_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cme_ctrl
// Sequencer of the executor: takes items, fetches and decodes instructions
// from the word memory, does the data access, and holds the result register.
// ----------------------------------------------------------------------------
module cme_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  cme_pkg::cmd_item_t                  cmd,
	output logic                                res_valid,
	input  logic                                res_stall,
	output cme_pkg::res_item_t                  res,
	output cme_pkg::mem_req_t                   mem,
	input  logic [cme_pkg::WORD_W-1:0]          rd_word
);

	// Architectural state.
	cme_pkg::state_t                 state_q, state_d;
	logic [cme_pkg::WORD_W-1:0]      r_q, r_d;
	logic                            tog_q, tog_d;
	logic [cme_pkg::ADDR_W-1:0]      pc_q, pc_d;
	logic                            stop_q, stop_d;

	// Work registers of the current item.
	cme_pkg::res_item_t              pend_q, pend_d;
	logic [cme_pkg::ADDR_W-1:0]      ptr_q, ptr_d;
	logic [cme_pkg::CNT_W-1:0]       cnt_q, cnt_d;
	cme_pkg::dop_t                   dop_q, dop_d;

	// Output register.
	logic                            out_valid_q, out_valid_d;
	cme_pkg::res_item_t              out_q, out_d;

	// Fields of the fetched instruction.
	logic [7:0]                      c0, c1, c2, c3;
	logic [3:0]                      d2, d3;
	logic                            dig2, dig3;
	logic [cme_pkg::ADDR_W-1:0]      opnd;
	logic [cme_pkg::ADDR_W-1:0]      base;
	logic                            blk_ok;
	logic                            pc_over;
	cme_pkg::res_item_t              plain_res;

	assign c0 = rd_word[31:24];
	assign c1 = rd_word[23:16];
	assign c2 = rd_word[15:8];
	assign c3 = rd_word[7:0];
	assign d2 = 4'(c2 - cme_pkg::CH_ZERO);
	assign d3 = 4'(c3 - cme_pkg::CH_ZERO);
	assign dig2 = cme_pkg::is_digit(c2);
	assign dig3 = cme_pkg::is_digit(c3);

	// Two-digit operand address and the base word of a block.
	assign opnd = 7'(7'(d2) * 7'(cme_pkg::DEC_BASE) + 7'(d3));
	assign base = 7'(8'(d2) * 8'(cme_pkg::BLOCK_WORDS));
	assign blk_ok = 8'((8'(d2) + 8'd1) * 8'(cme_pkg::BLOCK_WORDS))
		<= 8'(cme_pkg::MEM_WORDS);

	// The counter has run past the program area.
	assign pc_over = (pc_q >= 7'(cme_pkg::PC_LIMIT)) || (pc_q >= 7'(cme_pkg::MEM_WORDS));

	// Template of a single result with no data.
	assign plain_res = '{status: cme_pkg::STAT_EXEC, data_word: '0, block: '0,
		toggle: 1'b0, last: 1'b1};

	// Next state, memory requests and result generation.
	always_comb begin
		state_d     = state_q;
		r_d         = r_q;
		tog_d       = tog_q;
		pc_d        = pc_q;
		stop_d      = stop_q;
		pend_d      = pend_q;
		ptr_d       = ptr_q;
		cnt_d       = cnt_q;
		dop_d       = dop_q;
		out_valid_d = out_valid_q && res_stall;
		out_d       = out_q;
		mem         = '0;
		mem.raddr   = ptr_q;
		cmd_stall   = (state_q != cme_pkg::S_IDLE);

		unique case (state_q)
			cme_pkg::S_IDLE: begin
				if (cmd_valid) begin
					pend_d        = plain_res;
					pend_d.status = cme_pkg::STAT_ACK;
					state_d       = cme_pkg::S_EMIT;
					unique case (cmd.op)
						cme_pkg::OP_LOAD: begin
							if (cmd.address < 7'(cme_pkg::MEM_WORDS)) begin
								mem.we    = 1'b1;
								mem.waddr = cmd.address;
								mem.wdata = cmd.word;
							end
						end
						cme_pkg::OP_START: begin
							pc_d   = '0;
							stop_d = 1'b0;
						end
						cme_pkg::OP_STEP: begin
							if (stop_q) begin
								pend_d.status = cme_pkg::STAT_END;
							end else if (pc_over) begin
								stop_d        = 1'b1;
								pend_d.status = cme_pkg::STAT_END;
							end else begin
								mem.raddr = pc_q;
								state_d   = cme_pkg::S_FETCH;
							end
						end
						cme_pkg::OP_CLEAR: begin
							r_d       = '0;
							tog_d     = 1'b1;
							pc_d      = '0;
							stop_d    = 1'b0;
							mem.clear = 1'b1;
						end
					endcase
				end
			end

			cme_pkg::S_FETCH: begin
				pend_d  = plain_res;
				state_d = cme_pkg::S_EMIT;
				if (c0 == 8'h00) begin
					// An empty word ends the program.
					stop_d        = 1'b1;
					pend_d.status = cme_pkg::STAT_END;
				end else begin
					pc_d = 7'(pc_q + 7'd1);
					if ((c0 == cme_pkg::CH_G || c0 == cme_pkg::CH_P) &&
						c1 == cme_pkg::CH_D) begin
						if (!dig2 || !blk_ok) begin
							stop_d        = 1'b1;
							pend_d.status = cme_pkg::STAT_BAD;
						end else if (c0 == cme_pkg::CH_G) begin
							pend_d.status = cme_pkg::STAT_READ;
							pend_d.block  = d2;
						end else begin
							// Print walks the block one word at a time.
							pend_d.status = cme_pkg::STAT_PRINT;
							pend_d.block  = d2;
							ptr_d         = base;
							cnt_d         = '0;
							mem.raddr     = base;
							dop_d         = cme_pkg::DOP_PRINT;
							state_d       = cme_pkg::S_DATA;
						end
					end else if (c0 == cme_pkg::CH_H) begin
						stop_d        = 1'b1;
						pend_d.status = cme_pkg::STAT_HALT;
					end else if ((c1 == cme_pkg::CH_R && (c0 == cme_pkg::CH_L ||
						c0 == cme_pkg::CH_S || c0 == cme_pkg::CH_C)) ||
						(c0 == cme_pkg::CH_B && c1 == cme_pkg::CH_T)) begin
						if (!dig2 || !dig3 || opnd >= 7'(cme_pkg::MEM_WORDS)) begin
							stop_d        = 1'b1;
							pend_d.status = cme_pkg::STAT_BAD;
						end else if (c0 == cme_pkg::CH_L) begin
							mem.raddr = opnd;
							dop_d     = cme_pkg::DOP_LOAD_R;
							state_d   = cme_pkg::S_DATA;
						end else if (c0 == cme_pkg::CH_S) begin
							mem.we    = 1'b1;
							mem.waddr = opnd;
							mem.wdata = r_q;
						end else if (c0 == cme_pkg::CH_C) begin
							mem.raddr = opnd;
							dop_d     = cme_pkg::DOP_COMPARE;
							state_d   = cme_pkg::S_DATA;
						end else if (tog_q) begin
							pc_d = opnd;
						end
					end
				end
			end

			cme_pkg::S_DATA: begin
				state_d = cme_pkg::S_EMIT;
				unique case (dop_q)
					cme_pkg::DOP_LOAD_R: begin
						r_d = rd_word;
					end
					cme_pkg::DOP_COMPARE: begin
						tog_d = (rd_word == r_q);
					end
					cme_pkg::DOP_PRINT: begin
						pend_d.data_word = rd_word;
						pend_d.last = (cnt_q == cme_pkg::CNT_W'(cme_pkg::BLOCK_WORDS - 1));
					end
					default: begin
					end
				endcase
			end

			cme_pkg::S_EMIT: begin
				// Hand the result over once the output register is free.
				if (!out_valid_q || !res_stall) begin
					out_valid_d  = 1'b1;
					out_d        = pend_q;
					out_d.toggle = tog_q;
					if (pend_q.last) begin
						state_d = cme_pkg::S_IDLE;
					end else begin
						cnt_d     = cme_pkg::CNT_W'(cnt_q + 1'b1);
						ptr_d     = 7'(ptr_q + 7'd1);
						mem.raddr = 7'(ptr_q + 7'd1);
						state_d   = cme_pkg::S_DATA;
					end
				end
			end
		endcase
	end

	// Control and architectural registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cme_pkg::S_IDLE;
			r_q         <= '0;
			tog_q       <= 1'b1;
			pc_q        <= '0;
			stop_q      <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			dop_q       <= cme_pkg::DOP_LOAD_R;
		end else begin
			state_q     <= state_d;
			r_q         <= r_d;
			tog_q       <= tog_d;
			pc_q        <= pc_d;
			stop_q      <= stop_d;
			out_valid_q <= out_valid_d;
			cnt_q       <= cnt_d;
			dop_q       <= dop_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		ptr_q  <= ptr_d;
		out_q  <= out_d;
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

// ----- rtl/core/card_machine_instruction_executor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// card_machine_instruction_executor
// Small card machine: word memory, register R, toggle and counter, driven by
// load, start, step and clear items.
// ----------------------------------------------------------------------------
// Usage:
// An item on cmd is taken when cmd_valid is high and cmd_stall low. Results
// leave on res under res_valid/res_stall; the final result of an item has
// last set. One item is worked on at a time, and cmd_stall stays high until
// its last result is in the output register.
// Steps from acceptance to the result in the output register:
//   load, start, clear, and a step that ends at once: emit only
//   step of GD, H, SR, BT or an unknown word: fetch and decode, then emit
//   step of LR or CR: fetch and decode, one data read, then emit
//   step of PD: fetch and decode, then a data read and an emit for each word,
//   each word needing its own read of the single memory read port.
// The next item is taken the cycle after the last result is registered,
// even while that result still waits on res_stall.
// Reset and a job clear empty the memory at once through one flag per word;
// no sweep runs. While res_stall holds a result, the output register keeps
// it unchanged and the next result waits in the emit state.
module card_machine_instruction_executor (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  cme_pkg::cmd_item_t  cmd,
	output logic                res_valid,
	input  logic                res_stall,
	output cme_pkg::res_item_t  res
);

	cme_pkg::mem_req_t          mem;
	logic [cme_pkg::WORD_W-1:0] ram_rdata;
	logic                       rd_vld;
	logic [cme_pkg::WORD_W-1:0] rd_word;

	// Sequencer.
	cme_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.mem       (mem),
		.rd_word   (rd_word)
	);

	// Word memory.
	cme_ram #(
		.WIDTH (cme_pkg::WORD_W),
		.DEPTH (cme_pkg::MEM_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr[cme_pkg::MEM_AW-1:0]),
		.wdata (mem.wdata),
		.raddr (mem.raddr[cme_pkg::MEM_AW-1:0]),
		.rdata (ram_rdata)
	);

	// Written flags of the memory words.
	cme_vld u_vld (
		.clk    (clk),
		.arst_n (arst_n),
		.mem    (mem),
		.rd_vld (rd_vld)
	);

	// A word never written since reset or clear reads as zero.
	assign rd_word = rd_vld ? ram_rdata : '0;

endmodule
